// ===== rtl/tsc_pkg.sv =====
// Shared types, character codes and byte classifiers for the token scanner.
package tsc_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int MAX_LEXEME_DEF  = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_NEWLINE    = 8'h0a;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_RETURN     = 8'h0d;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_PLUS       = 8'h2b;
  localparam logic [7:0] CH_MINUS      = 8'h2d;
  localparam logic [7:0] CH_SLASH      = 8'h2f;
  localparam logic [7:0] CH_STAR       = 8'h2a;
  localparam logic [7:0] CH_SEMI       = 8'h3b;
  localparam logic [7:0] CH_EQUAL      = 8'h3d;
  localparam logic [7:0] CH_COMMA      = 8'h2c;
  localparam logic [7:0] CH_L          = 8'h6c;
  localparam logic [7:0] CH_E          = 8'h65;
  localparam logic [7:0] CH_T          = 8'h74;
  localparam logic [7:0] CH_P          = 8'h70;
  localparam logic [7:0] CH_U          = 8'h75;
  localparam logic [7:0] CH_S          = 8'h73;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_HALT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KW_NONE = 3'd0,
    KW_L    = 3'd1,
    KW_LE   = 3'd2,
    KW_LET  = 3'd3,
    KW_P    = 3'd4,
    KW_PU   = 3'd5,
    KW_PUT  = 3'd6,
    KW_PUTS = 3'd7
  } kw_t;

  typedef enum logic [3:0] {
    KIND_INT   = 4'd0,
    KIND_IDENT = 4'd1,
    KIND_LET   = 4'd2,
    KIND_PUTS  = 4'd3,
    KIND_PLUS  = 4'd4,
    KIND_MINUS = 4'd5,
    KIND_SLASH = 4'd6,
    KIND_STAR  = 4'd7,
    KIND_SEMI  = 4'd8,
    KIND_EQUAL = 4'd9,
    KIND_COMMA = 4'd10,
    KIND_ERROR = 4'd11
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [6:0]  token_length;
    logic [7:0]  bad_byte;
    logic        last_of_run;
  } out_item_t;

  // Up to two results pushed into the output queue per request.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_numeral(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {CH_SPACE, CH_NEWLINE, CH_TAB, CH_RETURN};
  endfunction

  function automatic logic is_punct(logic [7:0] b);
    return b inside {CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_SEMI, CH_EQUAL, CH_COMMA};
  endfunction

  function automatic kind_t punct_kind(logic [7:0] b);
    kind_t k;
    case (b)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_SLASH: k = KIND_SLASH;
      CH_STAR:  k = KIND_STAR;
      CH_SEMI:  k = KIND_SEMI;
      CH_EQUAL: k = KIND_EQUAL;
      default:  k = KIND_COMMA;
    endcase
    return k;
  endfunction

  function automatic kw_t kw_first(logic [7:0] b);
    kw_t k;
    case (b)
      CH_L:    k = KW_L;
      CH_P:    k = KW_P;
      default: k = KW_NONE;
    endcase
    return k;
  endfunction

  function automatic kw_t kw_next(kw_t p, logic [7:0] b);
    kw_t k;
    k = KW_NONE;
    case (p)
      KW_L:    if (b == CH_E) k = KW_LE;
      KW_LE:   if (b == CH_T) k = KW_LET;
      KW_P:    if (b == CH_U) k = KW_PU;
      KW_PU:   if (b == CH_T) k = KW_PUT;
      KW_PUT:  if (b == CH_S) k = KW_PUTS;
      default: k = KW_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t pending_kind(mode_t m, kw_t kw);
    kind_t k;
    if (m == MODE_NUMBER) begin
      k = KIND_INT;
    end else if (kw == KW_LET) begin
      k = KIND_LET;
    end else if (kw == KW_PUTS) begin
      k = KIND_PUTS;
    end else begin
      k = KIND_IDENT;
    end
    return k;
  endfunction

endpackage

// ===== rtl/token_scanner.sv =====
// Token scanner top level: byte classing, token state and result queue.
// Results: a result is written into the result queue when its byte's request is accepted
// and is on out_data once the results ahead of it have gone; a second one from the same byte follows the first.
// Throughput: one byte per cycle; in_ready drops only while fewer than two of the
// four result queue slots are free, i.e. when the consumer stalls.
// Reset (synchronous): scanner idle, offsets and counts zero, result queue empty.
module token_scanner
  import tsc_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int MAX_LEXEME  = MAX_LEXEME_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(MAX_LEXEME + 1);

  mode_t                  mode, mode_next;
  kw_t                    kw, kw_next_q;
  logic [OFFSET_BITS-1:0] start, start_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [CW-1:0]          cnt, cnt_next;

  logic      accept;
  logic      space;
  logic      taken;
  logic      a_valid, x_valid;
  out_item_t a_item, x_item;
  push_t     push;
  mode_t     mode1;
  kw_t       kw1;
  logic [OFFSET_BITS-1:0] start1;
  logic [CW-1:0]          cnt1;
  logic [7:0]             b;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.text_byte;
  assign taken    = ((mode == MODE_IDENT) && (is_letter(b) || is_numeral(b))) ||
                    ((mode == MODE_NUMBER) && is_numeral(b));

  always_comb begin
    a_valid = 1'b0;
    a_item  = '0;
    x_valid = 1'b0;
    x_item  = '0;
    mode1   = mode;
    kw1     = kw;
    start1  = start;
    cnt1    = cnt;

    if (mode != MODE_HALT) begin
      if (taken) begin
        if (mode == MODE_IDENT) begin
          kw1 = kw_next(kw, b);
        end
        if (cnt < CW'(MAX_LEXEME)) begin
          cnt1 = cnt + 1'b1;
        end
      end else begin
        // Flush the token this byte ends, then treat the byte as if idle.
        if (mode == MODE_IDENT || mode == MODE_NUMBER) begin
          a_valid             = 1'b1;
          a_item.token_kind   = pending_kind(mode, kw);
          a_item.token_start  = 16'(start);
          a_item.token_length = 7'(cnt);
        end
        mode1 = MODE_IDLE;
        kw1   = KW_NONE;
        cnt1  = '0;
        if (is_space(b)) begin
          mode1 = MODE_IDLE;
        end else if (is_punct(b)) begin
          x_valid             = 1'b1;
          x_item.token_kind   = punct_kind(b);
          x_item.token_start  = 16'(offset);
          x_item.token_length = 7'd1;
        end else if (is_letter(b)) begin
          mode1  = MODE_IDENT;
          start1 = offset;
          cnt1   = CW'(1);
          kw1    = kw_first(b);
        end else if (is_numeral(b)) begin
          mode1  = MODE_NUMBER;
          start1 = offset;
          cnt1   = CW'(1);
        end else begin
          x_valid             = 1'b1;
          x_item.token_kind   = KIND_ERROR;
          x_item.token_start  = 16'(offset);
          x_item.token_length = 7'd1;
          x_item.bad_byte     = b;
          mode1               = MODE_HALT;
        end
      end
    end

    // Final byte: flush whatever token is still open. Cannot coincide with
    // a punctuation or error result, as those leave no open token.
    if (in_data.end_of_text && (mode1 == MODE_IDENT || mode1 == MODE_NUMBER)) begin
      x_valid             = 1'b1;
      x_item              = '0;
      x_item.token_kind   = pending_kind(mode1, kw1);
      x_item.token_start  = 16'(start1);
      x_item.token_length = 7'(cnt1);
    end

    push = '0;
    if (accept) begin
      push.count = 2'(a_valid) + 2'(x_valid);
      if (a_valid) begin
        push.first  = a_item;
        push.second = x_item;
      end else begin
        push.first = x_item;
      end
      if (push.count == 2'd2) begin
        push.second.last_of_run = 1'b1;
      end else begin
        push.first.last_of_run = 1'b1;
      end
    end

    mode_next   = mode;
    kw_next_q   = kw;
    start_next  = start;
    cnt_next    = cnt;
    offset_next = offset;
    if (accept) begin
      if (in_data.end_of_text) begin
        mode_next   = MODE_IDLE;
        kw_next_q   = KW_NONE;
        start_next  = '0;
        cnt_next    = '0;
        offset_next = '0;
      end else begin
        mode_next   = mode1;
        kw_next_q   = kw1;
        start_next  = start1;
        cnt_next    = cnt1;
        offset_next = offset + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      kw     <= KW_NONE;
      start  <= '0;
      cnt    <= '0;
      offset <= '0;
    end else begin
      mode   <= mode_next;
      kw     <= kw_next_q;
      start  <= start_next;
      cnt    <= cnt_next;
      offset <= offset_next;
    end
  end

  tsc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_HALT) |-> (push.count == 2'd0))
    else $error("result produced while halted");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_of_text) |=> (mode == MODE_IDLE && offset == '0 && cnt == '0))
    else $error("final byte did not restart the scanner");

  a_kw_only_ident: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_IDENT) |-> (kw == KW_NONE && cnt == '0) || (mode == MODE_NUMBER))
    else $error("keyword progress outside an identifier");

  a_open_token_len: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDENT || mode == MODE_NUMBER) |->
      (cnt != '0 && cnt <= CW'(MAX_LEXEME)))
    else $error("open token with bad length");

endmodule

// ===== rtl/tsc_out_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
module tsc_out_queue
  import tsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Always leave room for the worst case of two results.
  assign space     = (count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (QUEUE_CNT_BITS'(QUEUE_DEPTH) - count >= QUEUE_CNT_BITS'(push.count)))
    else $error("push into a queue without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != QUEUE_CNT_BITS'(QUEUE_DEPTH)) |->
      (QUEUE_PTR_BITS'(wr_ptr - rd_ptr) == QUEUE_PTR_BITS'(count)))
    else $error("queue pointers disagree with fill count");

endmodule

// ===== verif/token_checker.sv =====
// Token scanner checker: follows both channels, predicts tokens and compares results.
`timescale 1ns / 100ps
module token_checker
  import tsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        results_waiting
);

  mode_t       mode_r;
  logic [15:0] tok_start_r;
  logic [6:0]  tok_len_r;
  kw_t         kw_r;
  logic [15:0] pos_r;
  out_item_t   token_queue[$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 50) begin
      $display("%0t: token mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic word_char(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == CH_UNDERSCORE;
  endfunction

  function automatic logic digit_char(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic blank_char(input logic [7:0] b);
    return b == CH_SPACE || b == CH_NEWLINE || b == CH_TAB || b == CH_RETURN;
  endfunction

  function automatic logic punct_code(input logic [7:0] b, output kind_t k);
    logic hit;
    hit = 1'b1;
    k = KIND_ERROR;
    case (b)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_SLASH: k = KIND_SLASH;
      CH_STAR:  k = KIND_STAR;
      CH_SEMI:  k = KIND_SEMI;
      CH_EQUAL: k = KIND_EQUAL;
      CH_COMMA: k = KIND_COMMA;
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic kw_t kw_advance(input kw_t p, input logic [7:0] b);
    kw_t nxt;
    nxt = KW_NONE;
    if (p == KW_L && b == CH_E) nxt = KW_LE;
    else if (p == KW_LE && b == CH_T) nxt = KW_LET;
    else if (p == KW_P && b == CH_U) nxt = KW_PU;
    else if (p == KW_PU && b == CH_T) nxt = KW_PUT;
    else if (p == KW_PUT && b == CH_S) nxt = KW_PUTS;
    return nxt;
  endfunction

  function automatic void add_token(input kind_t k, input logic [15:0] s,
                                    input logic [6:0] len, input logic [7:0] bad);
    out_item_t t;
    t.token_kind   = k;
    t.token_start  = s;
    t.token_length = len;
    t.bad_byte     = bad;
    t.last_of_run  = 1'b0;
    token_queue = {token_queue, t};
  endfunction

  // Emit the word or number being gathered, if any, and drop back to idle.
  function automatic void close_token();
    kind_t k;
    if (mode_r == MODE_IDENT || mode_r == MODE_NUMBER) begin
      if (mode_r == MODE_NUMBER) begin
        k = KIND_INT;
      end else begin
        case (kw_r)
          KW_LET:  k = KIND_LET;
          KW_PUTS: k = KIND_PUTS;
          default: k = KIND_IDENT;
        endcase
      end
      add_token(k, tok_start_r, tok_len_r, 8'h00);
      mode_r    = MODE_IDLE;
      tok_len_r = '0;
      kw_r      = KW_NONE;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic eot);
    int        size_at_entry;
    kind_t     pk;
    out_item_t tail;
    size_at_entry = token_queue.size();
    if (mode_r != MODE_HALT) begin
      if ((mode_r == MODE_IDENT && (word_char(b) || digit_char(b))) ||
          (mode_r == MODE_NUMBER && digit_char(b))) begin
        if (mode_r == MODE_IDENT) kw_r = kw_advance(kw_r, b);
        if (tok_len_r < MAX_LEXEME_DEF) tok_len_r = tok_len_r + 7'd1;
      end else begin
        close_token();
        if (blank_char(b)) begin
          // skip whitespace
        end else if (punct_code(b, pk)) begin
          add_token(pk, pos_r, 7'd1, 8'h00);
        end else if (word_char(b) || digit_char(b)) begin
          mode_r      = word_char(b) ? MODE_IDENT : MODE_NUMBER;
          tok_start_r = pos_r;
          tok_len_r   = 7'd1;
          kw_r        = (b == CH_L) ? KW_L : (b == CH_P) ? KW_P : KW_NONE;
          if (mode_r == MODE_NUMBER) kw_r = KW_NONE;
        end else begin
          add_token(KIND_ERROR, pos_r, 7'd1, b);
          mode_r    = MODE_HALT;
          tok_len_r = '0;
          kw_r      = KW_NONE;
        end
      end
    end
    if (eot) begin
      close_token();
      mode_r      = MODE_IDLE;
      tok_len_r   = '0;
      kw_r        = KW_NONE;
      tok_start_r = '0;
      pos_r       = '0;
    end else begin
      pos_r = pos_r + 16'd1;
    end
    // Mark the final result of this request.
    if (token_queue.size() > size_at_entry) begin
      tail = token_queue.pop_back();
      tail.last_of_run = 1'b1;
      token_queue = {token_queue, tail};
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mode_r      = MODE_IDLE;
      tok_start_r = '0;
      tok_len_r   = '0;
      kw_r        = KW_NONE;
      pos_r       = '0;
      mismatches  = 0;
      token_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          report_mismatch("unexpected result kind", 16'(out_data.token_kind), 16'h0);
        end else begin
          want = token_queue.pop_front();
          if (out_data.token_kind !== want.token_kind)
            report_mismatch("token_kind", 16'(out_data.token_kind), 16'(want.token_kind));
          if (out_data.token_start !== want.token_start)
            report_mismatch("token_start", out_data.token_start, want.token_start);
          if (out_data.token_length !== want.token_length)
            report_mismatch("token_length", 16'(out_data.token_length),
                            16'(want.token_length));
          if (out_data.bad_byte !== want.bad_byte)
            report_mismatch("bad_byte", 16'(out_data.bad_byte), 16'(want.bad_byte));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 16'(out_data.last_of_run), 16'(want.last_of_run));
        end
      end
      if (in_valid && in_ready) scan_byte(in_data.text_byte, in_data.end_of_text);
    end
    results_waiting <= token_queue.size();
  end

endmodule

// ===== verif/token_scanner_test.sv =====
// Token scanner testbench top: clock, reset, text stimulus, receiver pacing and verdict.
`timescale 1ns / 100ps
module token_scanner_test
  import tsc_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int results_waiting;
  int in_idle_pct  = 21;
  int out_idle_pct = 47;
  int bytes_sent   = 0;
  int stall_cycles = 0;
  bit hold_off_req = 1'b0;
  logic [7:0] text_buf[$];

  token_scanner uut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  token_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .mismatches, .results_waiting
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver pacing; a hold-off request stalls it for a long stretch.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= '{text_byte: b, end_of_text: eot};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // Append one byte to the pending text.
  task automatic add_char(input logic [7:0] c);
    text_buf = {text_buf, c};
  endtask

  function automatic logic [7:0] pick_word_char(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'(r) + 8'h61;
    if (r < 52) return 8'(r - 26) + 8'h41;
    if (r == 52) return CH_UNDERSCORE;
    return 8'(r - 53) + 8'h30;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_NEWLINE;
      2:       return CH_TAB;
      default: return CH_RETURN;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(6))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_SLASH;
      3:       return CH_STAR;
      4:       return CH_SEMI;
      5:       return CH_EQUAL;
      default: return CH_COMMA;
    endcase
  endfunction

  // Keywords and near misses of them.
  function automatic string keyword_like(input int i);
    case (i)
      0:       return "let";
      1:       return "puts";
      2:       return "le";
      3:       return "lets";
      4:       return "pu";
      5:       return "put";
      6:       return "putsx";
      7:       return "l";
      8:       return "p";
      default: return "let9";
    endcase
  endfunction

  task automatic append_token();
    int    sel;
    int    len;
    int    i;
    string w;
    sel = $urandom_range(99);
    if (sel < 14) begin
      w = keyword_like($urandom_range(9));
      for (i = 0; i < w.len(); i++) add_char(w[i]);
    end else if (sel < 62) begin
      // mostly short lexemes, now and then a long one near or past the length limit
      len = ($urandom_range(24) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 8);
      if (sel < 40) begin
        add_char(pick_word_char(1'b1));
        for (i = 1; i < len; i++) add_char(pick_word_char(1'b0));
      end else begin
        for (i = 0; i < len; i++) add_char(8'($urandom_range(9)) + 8'h30);
      end
    end else if (sel < 84) begin
      add_char(pick_punct());
    end else begin
      repeat ($urandom_range(1, 3)) add_char(pick_blank());
    end
  endtask

  task automatic build_text(input int ntok, input bit clean);
    int noise_at;
    int i;
    noise_at = -1;
    if (!clean && $urandom_range(9) < 3) noise_at = $urandom_range(ntok - 1);
    for (i = 0; i < ntok; i++) begin
      if (i == noise_at) repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(255)));
      else append_token();
      if ($urandom_range(9) < 4) add_char(pick_blank());
    end
  endtask

  task automatic send_text(input bit with_eot);
    logic [7:0] b;
    while (text_buf.size() != 0) begin
      b = text_buf.pop_front();
      push_byte(b, with_eot && text_buf.size() == 0);
    end
  endtask

  task automatic run_phase(input int in_pct, input int out_pct, input int until_count);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    while (bytes_sent < until_count) begin
      build_text($urandom_range(1, 10), 1'b0);
      send_text(1'b1);
    end
  endtask

  // Hold off the sender until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_waiting != 0);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_string("let\tputs\015");
    push_string("x_9=12ab");
    push_string("+-/*;,");
    push_byte(CH_UNDERSCORE, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);

    run_phase(21, 47, 300);
    hold_off_req = 1'b1;
    run_phase(21, 47, 600);
    run_phase(47, 21, 900);
    drain_results();
    run_phase(47, 21, 1200);
    run_phase(0, 0, 1750);

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
